>>> rtl/tcch_pkg.sv
// ----------------------------------------------------------------------------
// tcch_pkg
// Constants and the arctangent table for the tilt-compensated compass heading.
// ----------------------------------------------------------------------------
package tcch_pkg;

  localparam int TABLE_LEN = 24;

  // angles in 1/64 degree
  localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
  localparam logic signed [16:0] HALF_TURN    = 17'sd11520;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;

  // 1/K in Q30
  localparam logic signed [32:0] INV_GAIN_Q30 = 33'sd652032874;

  // 180 degrees in 2^-16 degree units
  localparam logic signed [25:0] HALF_TURN_FINE = 26'sd11796480;

  localparam logic signed [14:0] DECL_RESET = 15'sd192;

  // atan(2^-i) in 2^-16 degree units
  function automatic logic [21:0] atan_entry(input int i);
    logic [21:0] r;
    case (i)
      0:  r = 22'd2949120;
      1:  r = 22'd1740967;
      2:  r = 22'd919879;
      3:  r = 22'd466945;
      4:  r = 22'd234379;
      5:  r = 22'd117304;
      6:  r = 22'd58666;
      7:  r = 22'd29335;
      8:  r = 22'd14668;
      9:  r = 22'd7334;
      10: r = 22'd3667;
      11: r = 22'd1833;
      12: r = 22'd917;
      13: r = 22'd458;
      14: r = 22'd229;
      15: r = 22'd115;
      16: r = 22'd57;
      17: r = 22'd29;
      18: r = 22'd14;
      19: r = 22'd7;
      20: r = 22'd4;
      21: r = 22'd2;
      22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/tilt_compensated_compass_heading.sv
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading
// Pipelined tilt-compensated compass: CORDIC sin/cos of roll and pitch,
// field rotation into the horizontal plane, CORDIC atan2, declination add.
// ----------------------------------------------------------------------------
//  channel      | direction | handshake                     | payload
//  input        | in        | in_valid / in_stall           | mag_x, mag_y, mag_z,
//               |           |                               | roll_angle, pitch_angle
//  result       | out       | out_valid / out_stall         | heading
//  declination  | in        | declination_valid / _ready    | declination
//
//  2*CORDIC_STAGES+8 register stages, one word accepted per cycle while
//  in_stall is low; each pipeline stage moves on when its successor is empty
//  or moving, so bubbles collapse and a stalled result holds only the full
//  stages behind it
//  in_stall rises only when every stage holds a word
//  synchronous active-high reset clears all valid bits and sets declination
//  to +3 degrees; declination_ready is always high
// ----------------------------------------------------------------------------
module tilt_compensated_compass_heading #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [20:0] mag_x,
  input  logic signed [20:0] mag_y,
  input  logic signed [20:0] mag_z,
  input  logic signed [14:0] roll_angle,
  input  logic signed [14:0] pitch_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [14:0] heading,
  input  logic               declination_valid,
  output logic               declination_ready,
  input  logic signed [14:0] declination
);

  localparam int N    = CORDIC_STAGES;
  localparam int RW   = 33;      // rotation x/y
  localparam int ZW   = 25;      // rotation angle
  localparam int VW   = 40;      // vectoring x/y
  localparam int VZW  = 26;      // vectoring angle
  localparam int S_NEG  = N + 1;
  localparam int S_MUL1 = N + 2;
  localparam int S_MUL2 = N + 3;
  localparam int S_SUM  = N + 4;
  localparam int S_VPRE = N + 5;
  localparam int S_DECL = 2 * N + 6;
  localparam int S_OUT  = 2 * N + 7;
  localparam int L      = 2 * N + 8;

  logic [L-1:0] vld;
  logic [L-1:0] adv;

  logic signed [14:0] decl;

  always_ff @(posedge clk) begin
    if (rst) begin
      decl <= tcch_pkg::DECL_RESET;
    end else if (declination_valid) begin
      decl <= declination;
    end
  end
  assign declination_ready = 1'b1;

  // stage advance chain
  always_comb begin
    adv[L-1] = !vld[L-1] || !out_stall;
    for (int i = L - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < L; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[S_OUT];

  // ---------------- angle folding
  function automatic logic signed [16:0] wrap_half(input logic signed [14:0] a);
    logic signed [16:0] t;
    t = 17'(a);
    if (t >= tcch_pkg::HALF_TURN) begin
      t = t - tcch_pkg::FULL_TURN;
    end else if (t < -tcch_pkg::HALF_TURN) begin
      t = t + tcch_pkg::FULL_TURN;
    end
    return t;
  endfunction

  logic signed [16:0] roll_w, pitch_w, roll_f, pitch_f;
  logic               roll_n, pitch_n;

  always_comb begin
    roll_w  = wrap_half(roll_angle);
    pitch_w = wrap_half(pitch_angle);
    roll_f  = roll_w;
    roll_n  = 1'b0;
    if (roll_w > tcch_pkg::QUARTER_TURN) begin
      roll_f = roll_w - tcch_pkg::HALF_TURN;
      roll_n = 1'b1;
    end else if (roll_w < -tcch_pkg::QUARTER_TURN) begin
      roll_f = roll_w + tcch_pkg::HALF_TURN;
      roll_n = 1'b1;
    end
    pitch_f = pitch_w;
    pitch_n = 1'b0;
    if (pitch_w > tcch_pkg::QUARTER_TURN) begin
      pitch_f = pitch_w - tcch_pkg::HALF_TURN;
      pitch_n = 1'b1;
    end else if (pitch_w < -tcch_pkg::QUARTER_TURN) begin
      pitch_f = pitch_w + tcch_pkg::HALF_TURN;
      pitch_n = 1'b1;
    end
  end

  // ---------------- rotation CORDIC, roll and pitch side by side
  logic signed [RW-1:0] rx [0:N];
  logic signed [RW-1:0] ry [0:N];
  logic signed [ZW-1:0] rz [0:N];
  logic signed [RW-1:0] px [0:N];
  logic signed [RW-1:0] py [0:N];
  logic signed [ZW-1:0] pz [0:N];
  logic                 rneg [0:N];
  logic                 pneg [0:N];
  logic signed [20:0]   mgx [0:N];
  logic signed [20:0]   mgy [0:N];
  logic signed [20:0]   mgz [0:N];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rx[0]   <= tcch_pkg::INV_GAIN_Q30;
      ry[0]   <= '0;
      rz[0]   <= ZW'(roll_f) <<< 10;
      px[0]   <= tcch_pkg::INV_GAIN_Q30;
      py[0]   <= '0;
      pz[0]   <= ZW'(pitch_f) <<< 10;
      rneg[0] <= roll_n;
      pneg[0] <= pitch_n;
      mgx[0]  <= mag_x;
      mgy[0]  <= mag_y;
      mgz[0]  <= mag_z;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_rot
    localparam logic signed [ZW-1:0] ATN = ZW'(tcch_pkg::atan_entry(k));
    always_ff @(posedge clk) begin
      if (adv[k+1]) begin
        if (rz[k] >= 0) begin
          rx[k+1] <= rx[k] - (ry[k] >>> k);
          ry[k+1] <= ry[k] + (rx[k] >>> k);
          rz[k+1] <= rz[k] - ATN;
        end else begin
          rx[k+1] <= rx[k] + (ry[k] >>> k);
          ry[k+1] <= ry[k] - (rx[k] >>> k);
          rz[k+1] <= rz[k] + ATN;
        end
        if (pz[k] >= 0) begin
          px[k+1] <= px[k] - (py[k] >>> k);
          py[k+1] <= py[k] + (px[k] >>> k);
          pz[k+1] <= pz[k] - ATN;
        end else begin
          px[k+1] <= px[k] + (py[k] >>> k);
          py[k+1] <= py[k] - (px[k] >>> k);
          pz[k+1] <= pz[k] + ATN;
        end
        rneg[k+1] <= rneg[k];
        pneg[k+1] <= pneg[k];
        mgx[k+1]  <= mgx[k];
        mgy[k+1]  <= mgy[k];
        mgz[k+1]  <= mgz[k];
      end
    end
  end

  // ---------------- sign restore
  logic signed [31:0] sr0, cr0, sp0, cp0;
  logic signed [20:0] mx1, my1, mz1;

  always_ff @(posedge clk) begin
    if (adv[S_NEG]) begin
      sr0 <= 32'(rneg[N] ? -ry[N] : ry[N]);
      cr0 <= 32'(rneg[N] ? -rx[N] : rx[N]);
      sp0 <= 32'(pneg[N] ? -py[N] : py[N]);
      cp0 <= 32'(pneg[N] ? -px[N] : px[N]);
      mx1 <= mgx[N];
      my1 <= mgy[N];
      mz1 <= mgz[N];
    end
  end

  // ---------------- sin r sin p, cos r sin p
  logic signed [63:0] srsp_full, crsp_full;
  logic signed [31:0] srsp, crsp, sr1, cr1, cp1;
  logic signed [20:0] mx2, my2, mz2;

  assign srsp_full = 64'(sr0) * 64'(sp0);
  assign crsp_full = 64'(cr0) * 64'(sp0);

  always_ff @(posedge clk) begin
    if (adv[S_MUL1]) begin
      srsp <= srsp_full[61:30];
      crsp <= crsp_full[61:30];
      sr1  <= sr0;
      cr1  <= cr0;
      cp1  <= cp0;
      mx2  <= mx1;
      my2  <= my1;
      mz2  <= mz1;
    end
  end

  // ---------------- field products
  logic signed [52:0] p_xc, p_ys, p_zc, p_yc, p_zs;

  always_ff @(posedge clk) begin
    if (adv[S_MUL2]) begin
      p_xc <= 53'(mx2) * 53'(cp1);
      p_ys <= 53'(my2) * 53'(srsp);
      p_zc <= 53'(mz2) * 53'(crsp);
      p_yc <= 53'(my2) * 53'(cr1);
      p_zs <= 53'(mz2) * 53'(sr1);
    end
  end

  // ---------------- horizontal components
  logic signed [54:0] sum_x, sum_y;
  logic signed [VW-1:0] xp, yp;

  assign sum_x = 55'(p_xc) + 55'(p_ys) + 55'(p_zc);
  assign sum_y = 55'(p_yc) - 55'(p_zs);

  always_ff @(posedge clk) begin
    if (adv[S_SUM]) begin
      xp <= VW'(sum_x >>> 16);
      yp <= VW'(sum_y >>> 16);
    end
  end

  // ---------------- vectoring CORDIC
  logic signed [VW-1:0]  vx [0:N];
  logic signed [VW-1:0]  vy [0:N];
  logic signed [VZW-1:0] vz [0:N];
  logic                  vzero [0:N];

  always_ff @(posedge clk) begin
    if (adv[S_VPRE]) begin
      vzero[0] <= (xp == '0) && (yp == '0);
      if (xp < 0) begin
        vx[0] <= -xp;
        vy[0] <= -yp;
        vz[0] <= tcch_pkg::HALF_TURN_FINE;
      end else begin
        vx[0] <= xp;
        vy[0] <= yp;
        vz[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_vec
    localparam logic signed [VZW-1:0] ATN = VZW'(tcch_pkg::atan_entry(k));
    always_ff @(posedge clk) begin
      if (adv[S_VPRE+1+k]) begin
        if (vy[k] >= 0) begin
          vx[k+1] <= vx[k] + (vy[k] >>> k);
          vy[k+1] <= vy[k] - (vx[k] >>> k);
          vz[k+1] <= vz[k] + ATN;
        end else begin
          vx[k+1] <= vx[k] - (vy[k] >>> k);
          vy[k+1] <= vy[k] + (vx[k] >>> k);
          vz[k+1] <= vz[k] - ATN;
        end
        vzero[k+1] <= vzero[k];
      end
    end
  end

  // ---------------- declination and rounding
  logic signed [26:0] hsum;
  logic signed [16:0] hq;

  assign hsum = (vzero[N] ? 27'sd0 : 27'(vz[N])) + (27'(decl) <<< 10) + 27'sd512;

  always_ff @(posedge clk) begin
    if (adv[S_DECL]) begin
      hq <= hsum[26:10];
    end
  end

  // wrap into one turn
  always_ff @(posedge clk) begin
    if (adv[S_OUT]) begin
      if (hq < 0) begin
        heading <= 15'(hq + tcch_pkg::FULL_TURN);
      end else if (hq >= tcch_pkg::FULL_TURN) begin
        heading <= 15'(hq - tcch_pkg::FULL_TURN);
      end else begin
        heading <= 15'(hq);
      end
    end
  end

  // ---------------- checks
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading < 15'(tcch_pkg::FULL_TURN)))
    else $error("heading outside one turn");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&vld))
    else $error("input stalled with an empty stage");

  a_word_moves: assert property (@(posedge clk) disable iff (rst)
    (vld[S_DECL] && !out_valid) |=> out_valid)
    else $error("word lost before the output register");

endmodule

>>> dv/tcch_checker.sv
// ----------------------------------------------------------------------------
// tcch_checker
// Watches the sample and heading channels of the compass block, predicts each
// heading from the accepted sample and the current declination, and compares.
// ----------------------------------------------------------------------------
module tcch_checker #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [20:0] mag_x,
  input  logic signed [20:0] mag_y,
  input  logic signed [20:0] mag_z,
  input  logic signed [14:0] roll_angle,
  input  logic signed [14:0] pitch_angle,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic        [14:0] heading,
  input  logic               declination_valid,
  input  logic               declination_ready,
  input  logic signed [14:0] declination,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ATAN_FINE [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  longint decl_now;
  logic [14:0] heading_q[$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint wrap_deg(longint v);
    longint r;
    r = v % 23040;
    if (r < 0) r += 23040;
    return r;
  endfunction

  function automatic void rotate_sincos(longint a, output longint s, output longint c);
    longint x, y, z, nx;
    bit flip;
    x = 652032874;
    y = 0;
    flip = 0;
    a = wrap_deg(a);
    if (a >= 11520) a -= 23040;
    if (a > 5760) begin
      a -= 11520;
      flip = 1;
    end else if (a < -5760) begin
      a += 11520;
      flip = 1;
    end
    z = a * 1024;
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= ATAN_FINE[i];
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += ATAN_FINE[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 64'sd11796480;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      if (y >= 0) begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += ATAN_FINE[i];
      end else begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= ATAN_FINE[i];
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic logic [14:0] predict_heading(longint mx, longint my, longint mz,
                                                   longint roll, longint pitch,
                                                   longint decl);
    longint sr, cr, sp, cp, srsp, crsp, xh, yh, v;
    rotate_sincos(roll, sr, cr);
    rotate_sincos(pitch, sp, cp);
    srsp = floor_shift(sr * sp, 30);
    crsp = floor_shift(cr * sp, 30);
    xh = floor_shift(mx * cp + my * srsp + mz * crsp, 16);
    yh = floor_shift(my * cr - mz * sr, 16);
    v = vector_angle(yh, xh) + decl * 1024 + 512;
    return 15'(wrap_deg(floor_shift(v, 10)));
  endfunction

  always @(posedge clk) begin
    logic [14:0] want;
    if (rst) begin
      decl_now <= 192;
      heading_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        heading_q.push_back(predict_heading(mag_x, mag_y, mag_z, roll_angle,
                                            pitch_angle, decl_now));
      if (out_valid && !out_stall) begin
        if (heading_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected heading word %0d", heading);
          fail_count <= fail_count + 1;
        end else begin
          want = heading_q.pop_front();
          if (want !== heading) begin
            if (fail_count < 10)
              $display("heading mismatch: expected %0d got %0d", want, heading);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (declination_valid && declination_ready) decl_now <= declination;
    end
    pending = heading_q.size();
  end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives samples and declination settings into the compass block with random
// gaps and output stalls; the checker predicts and compares every heading.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 2 * 16 + 8;
  localparam int WATCHDOG = 5000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic signed [20:0] mag_x = 0, mag_y = 0, mag_z = 0;
  logic signed [14:0] roll_angle = 0, pitch_angle = 0;
  logic [14:0] heading;
  logic declination_valid = 0, declination_ready;
  logic signed [14:0] declination = 0;
  int fail_count, pending, idle_cycles;
  bit stall_run = 1;

  initial forever #2 clk = ~clk;

  tilt_compensated_compass_heading i_dut (.*);

  tcch_checker i_chk (.*);

  // receiver stall pattern: alternating calm and busy stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_run = ~stall_run;
    out_stall <= stall_run ? ($urandom_range(0, 3) == 0) : 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (declination_valid && declination_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_word(logic signed [20:0] x, logic signed [20:0] y,
                           logic signed [20:0] z, logic signed [14:0] r,
                           logic signed [14:0] p);
    mag_x <= x;
    mag_y <= y;
    mag_z <= z;
    roll_angle <= r;
    pitch_angle <= p;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic pause_sender(int n);
    in_valid <= 0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_declination(logic signed [14:0] d);
    drain();
    declination <= d;
    declination_valid <= 1;
    do @(posedge clk); while (!declination_ready);
    @(negedge clk);
    declination_valid <= 0;
  endtask

  function automatic logic signed [14:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 15'($urandom);
      1: return 15'($urandom_range(0, 3) * 5760);
      default: return 15'(int'($urandom_range(0, 23040)) - 11520);
    endcase
  endfunction

  function automatic logic signed [20:0] pick_field();
    case ($urandom_range(0, 5))
      0: return 21'($urandom);
      1: return 21'(int'($urandom_range(0, 8)) - 4);
      default: return 21'(int'($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  initial begin
    int burst;
    logic signed [14:0] decl_set[6];
    decl_set = '{-11520, 11520, 0, -16384, 16383, 1234};
    repeat (7) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // field extremes, zero field, angle folding and out-of-range angles
    send_word(0, 0, 0, 0, 0);
    send_word(1048575, 0, 0, 0, 0);
    send_word(-1048576, 0, 0, 0, 0);
    send_word(0, 1048575, 0, 0, 0);
    send_word(0, -1048576, 0, 0, 0);
    send_word(-1048576, -1048576, -1048576, 0, 0);
    send_word(1048575, 1048575, 1048575, 11520, -11520);
    send_word(-5, 0, 0, 0, 0);
    send_word(-1000, 3, 0, 0, 0);
    send_word(1000, 0, 500000, 5760, 5760);
    send_word(1000, 2000, 500000, 5761, -5761);
    send_word(300000, -200000, 100000, -5760, 8000);
    send_word(300000, -200000, 100000, 16383, -16384);
    send_word(-300000, 200000, -100000, -16384, 16383);
    send_word(7, -7, 1, 1, -1);
    send_word(-1048576, 1048575, -1048576, 12000, -12000);
    send_word(1, 1, 1, 0, 0);

    foreach (decl_set[k]) begin
      set_declination(decl_set[k]);
      for (int n = 0; n < 100; ) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && n < 100; b++, n++)
          send_word(pick_field(), pick_field(), pick_field(), pick_angle(), pick_angle());
        if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
      end
    end
    set_declination(15'($urandom));
    for (int n = 0; n < 20; n++)
      send_word(pick_field(), pick_field(), pick_field(), pick_angle(), pick_angle());

    drain();
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

>>> filelist.f
rtl/tcch_pkg.sv
rtl/tilt_compensated_compass_heading.sv
dv/tcch_checker.sv
dv/tb_top.sv
